[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is applied.
`define GSCI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same, for an implication whose consequent is checked in the cycle after the antecedent.
`define GSCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `GSCI_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[src/gsci_pkg.sv]
package gsci_pkg;

    localparam int MAX_STOPS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);

    localparam int OFF_W     = 16;
    localparam int CH_W      = 8;
    localparam int LANES     = 4;
    localparam int COL_W     = CH_W * LANES;
    localparam int NUM_W     = CH_W + OFF_W;

    localparam int DIV_STEPS = CH_W;
    localparam int DIVC_W    = $clog2(DIV_STEPS);

    localparam logic [OFF_W-1:0] ONE_Q15 = OFF_W'(32768);

    // Beat kinds carried in the low tuser bit.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // Table read address selection.
    localparam logic [1:0] RD_FIRST  = 2'd0;
    localparam logic [1:0] RD_LAST   = 2'd1;
    localparam logic [1:0] RD_SECOND = 2'd2;
    localparam logic [1:0] RD_NEXT   = 2'd3;

    // Result source selection.
    localparam logic [1:0] RES_ZERO  = 2'd0;
    localparam logic [1:0] RES_COL   = 2'd1;
    localparam logic [1:0] RES_DIV   = 2'd2;

    typedef struct packed {
        logic       accept_load;
        logic       accept_eval;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       save_prev;
        logic       setup_en;
        logic       mul_en;
        logic       div_step;
        logic       res_en;
        logic [1:0] res_sel;
        logic       out_load;
    } gsci_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic pos_le;
        logic pos_ge;
        logic off_lt;
        logic d_zero;
    } gsci_stat_t;

endpackage

[src/gsci_ctrl.sv]
module gsci_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 in_func,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  gsci_pkg::gsci_stat_t stat,
    output gsci_pkg::gsci_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_SRCH  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_PACK  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [gsci_pkg::DIVC_W-1:0] div_cnt_reg, div_cnt_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_func == gsci_pkg::FUNC_LOAD) begin
                        cmd.accept_load = 1'b1;
                    end else begin
                        cmd.accept_eval = 1'b1;
                        cmd.rd_en       = 1'b1;
                        cmd.rd_sel      = gsci_pkg::RD_FIRST;
                        state_next      = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                if (stat.cnt_zero) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = gsci_pkg::RES_ZERO;
                    state_next  = S_OUT;
                end else if (stat.cnt_one || stat.pos_le) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = gsci_pkg::RES_COL;
                    state_next  = S_OUT;
                end else begin
                    cmd.save_prev = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = gsci_pkg::RD_LAST;
                    state_next    = S_LAST;
                end
            end
            S_LAST: begin
                if (stat.pos_ge) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = gsci_pkg::RES_COL;
                    state_next  = S_OUT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = gsci_pkg::RD_SECOND;
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (stat.off_lt) begin
                    cmd.save_prev = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = gsci_pkg::RD_NEXT;
                end else if (stat.d_zero) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = gsci_pkg::RES_COL;
                    state_next  = S_OUT;
                end else begin
                    cmd.setup_en = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en   = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == gsci_pkg::DIVC_W'(gsci_pkg::DIV_STEPS - 1)) begin
                    state_next = S_PACK;
                end
            end
            S_PACK: begin
                cmd.res_en  = 1'b1;
                cmd.res_sel = gsci_pkg::RES_DIV;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[src/gsci_datapath.sv]
module gsci_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gsci_pkg::gsci_cmd_t            cmd,
    output gsci_pkg::gsci_stat_t           stat,
    input  logic                           in_first,
    input  logic [gsci_pkg::OFF_W-1:0]     in_offset,
    input  logic [gsci_pkg::COL_W-1:0]     in_color,
    input  logic [gsci_pkg::OFF_W-1:0]     in_position,
    output logic [gsci_pkg::COL_W-1:0]     out_color
);

    // Stop tables: one write port for loads, one registered read port.
    logic [gsci_pkg::OFF_W-1:0] offset_mem [gsci_pkg::MAX_STOPS];
    logic [gsci_pkg::COL_W-1:0] color_mem  [gsci_pkg::MAX_STOPS];

    logic [gsci_pkg::CNT_W-1:0] count_reg, count_next;
    logic [gsci_pkg::OFF_W-1:0] last_reg, last_next;

    logic [gsci_pkg::CNT_W-1:0] base_cnt;
    logic [gsci_pkg::OFF_W-1:0] base_last;
    logic [gsci_pkg::OFF_W-1:0] off_clamp;
    logic                       load_ok;

    logic [gsci_pkg::IDX_W-1:0] raddr;
    logic [gsci_pkg::IDX_W-1:0] k_reg;
    logic [gsci_pkg::OFF_W-1:0] off_q_reg;
    logic [gsci_pkg::COL_W-1:0] col_q_reg;

    logic [gsci_pkg::OFF_W-1:0] pos_reg;
    logic [gsci_pkg::OFF_W-1:0] prev_off_reg;
    logic [gsci_pkg::COL_W-1:0] prev_col_reg;

    logic [gsci_pkg::OFF_W-1:0] d_reg, t_reg, dt_reg;
    logic [gsci_pkg::COL_W-1:0] ca_reg, cb_reg;

    logic [gsci_pkg::OFF_W-1:0] rem_reg [gsci_pkg::LANES];
    logic [gsci_pkg::CH_W-1:0]  low_reg [gsci_pkg::LANES];
    logic [gsci_pkg::CH_W-1:0]  quo_reg [gsci_pkg::LANES];
    logic [gsci_pkg::COL_W-1:0] quo_all;

    logic [gsci_pkg::COL_W-1:0] res_reg;
    logic [gsci_pkg::COL_W-1:0] out_reg;

    // Load: a first stop restarts the table; the offset never falls below the
    // previous one nor rises above 1.0.
    always_comb begin
        base_cnt  = in_first ? '0 : count_reg;
        base_last = in_first ? '0 : last_reg;
        load_ok   = base_cnt < gsci_pkg::CNT_W'(gsci_pkg::MAX_STOPS);
        off_clamp = (in_offset < base_last) ? base_last : in_offset;
        if (off_clamp > gsci_pkg::ONE_Q15) begin
            off_clamp = gsci_pkg::ONE_Q15;
        end
        count_next = count_reg;
        last_next  = last_reg;
        if (cmd.accept_load) begin
            count_next = base_cnt;
            last_next  = base_last;
            if (load_ok) begin
                count_next = base_cnt + 1'b1;
                last_next  = off_clamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            last_reg  <= '0;
        end else begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            gsci_pkg::RD_FIRST:  raddr = '0;
            gsci_pkg::RD_LAST:   raddr = gsci_pkg::IDX_W'(count_reg - 1'b1);
            gsci_pkg::RD_SECOND: raddr = gsci_pkg::IDX_W'(1);
            gsci_pkg::RD_NEXT:   raddr = k_reg + 1'b1;
            default:             raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_load && load_ok) begin
            offset_mem[base_cnt[gsci_pkg::IDX_W-1:0]] <= off_clamp;
            color_mem[base_cnt[gsci_pkg::IDX_W-1:0]]  <= in_color;
        end
        if (cmd.rd_en) begin
            off_q_reg <= offset_mem[raddr];
            col_q_reg <= color_mem[raddr];
            k_reg     <= raddr;
        end
    end

    assign stat.cnt_zero = count_reg == '0;
    assign stat.cnt_one  = count_reg == gsci_pkg::CNT_W'(1);
    assign stat.pos_le   = pos_reg <= off_q_reg;
    assign stat.pos_ge   = pos_reg >= off_q_reg;
    assign stat.off_lt   = off_q_reg < pos_reg;
    assign stat.d_zero   = off_q_reg == prev_off_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept_eval) begin
            pos_reg <= in_position;
        end
        if (cmd.save_prev) begin
            prev_off_reg <= off_q_reg;
            prev_col_reg <= col_q_reg;
        end
        if (cmd.setup_en) begin
            d_reg  <= off_q_reg - prev_off_reg;
            t_reg  <= pos_reg - prev_off_reg;
            dt_reg <= off_q_reg - pos_reg;
            ca_reg <= prev_col_reg;
            cb_reg <= col_q_reg;
        end
    end

    // Four channel lanes. The rounded numerator stays below 256*d, so the
    // top sixteen bits start below d and eight restoring steps give the quotient.
    always_ff @(posedge aclk) begin
        logic [gsci_pkg::NUM_W-1:0] num;
        logic [gsci_pkg::OFF_W:0]   trial;
        for (int i = 0; i < gsci_pkg::LANES; i++) begin
            if (cmd.mul_en) begin
                num = gsci_pkg::NUM_W'(ca_reg[i*gsci_pkg::CH_W +: gsci_pkg::CH_W])
                        * gsci_pkg::NUM_W'(dt_reg)
                    + gsci_pkg::NUM_W'(cb_reg[i*gsci_pkg::CH_W +: gsci_pkg::CH_W])
                        * gsci_pkg::NUM_W'(t_reg)
                    + gsci_pkg::NUM_W'(d_reg >> 1);
                rem_reg[i] <= num[gsci_pkg::NUM_W-1:gsci_pkg::CH_W];
                low_reg[i] <= num[gsci_pkg::CH_W-1:0];
                quo_reg[i] <= '0;
            end else if (cmd.div_step) begin
                trial = {rem_reg[i], low_reg[i][gsci_pkg::CH_W-1]};
                low_reg[i] <= {low_reg[i][gsci_pkg::CH_W-2:0], 1'b0};
                if (trial >= {1'b0, d_reg}) begin
                    rem_reg[i] <= gsci_pkg::OFF_W'(trial - {1'b0, d_reg});
                    quo_reg[i] <= {quo_reg[i][gsci_pkg::CH_W-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial[gsci_pkg::OFF_W-1:0];
                    quo_reg[i] <= {quo_reg[i][gsci_pkg::CH_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < gsci_pkg::LANES; i++) begin
            quo_all[i*gsci_pkg::CH_W +: gsci_pkg::CH_W] = quo_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_en) begin
            case (cmd.res_sel)
                gsci_pkg::RES_ZERO: res_reg <= '0;
                gsci_pkg::RES_COL:  res_reg <= col_q_reg;
                gsci_pkg::RES_DIV:  res_reg <= quo_all;
                default:            res_reg <= '0;
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign out_color = out_reg;

endmodule

[src/gradient_stop_color_interpolator_core.sv]
// Gradient colour-stop interpolator. Load beats (tuser bit 0 low) append one
// colour stop to a sixteen-entry table, with its offset clamped between the
// previous stop's offset and 1.0 (Q1.15, 32768); tuser bit 1 high restarts the
// table with that stop, and stops beyond the sixteenth are dropped. Evaluate
// beats (tuser bit 0 high) return one RGBA beat: transparent black for an empty
// table, the first colour at or below the first offset, the last colour at or
// above the last offset, and otherwise each channel interpolated between the
// two stops around the position, rounded to nearest with ties upward. A load
// beat keeps the input ready. An evaluate beat holds the input off while it
// reads the first stop, which settles an empty table or the first colour, then
// the last stop, which settles the last colour, and otherwise walks on from
// the second stop to the segment around the position, one entry per cycle,
// as the table has a single read port; the four channel lanes then run eight
// restoring division steps side by side. A finished result sits in the output
// register, so load beats continue to be taken while it waits; a further
// evaluate beat stalls only in its output state until that register is free.
module gradient_stop_color_interpolator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: stop_offset[15:0], stop_red[23:16],
    // stop_green[31:24], stop_blue[39:32], stop_alpha[47:40], position[63:48]
    input  logic [63:0] s_tdata,
    // s_tuser, lowest bit up: func[0], first_stop[1]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: out_red[7:0], out_green[15:8], out_blue[23:16],
    // out_alpha[31:24]
    output logic [31:0] m_tdata
);

    gsci_pkg::gsci_cmd_t  cmd;
    gsci_pkg::gsci_stat_t stat;

    // The controller sequences table reads, the division and the output beat.
    gsci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_func  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the stop tables, the channel lanes and the output data.
    gsci_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_first    (s_tuser[1]),
        .in_offset   (s_tdata[15:0]),
        .in_color    (s_tdata[47:16]),
        .in_position (s_tdata[63:48]),
        .out_color   (m_tdata)
    );

endmodule

[src/gsci_checker.sv]
`include "assert_macros.svh"

module gsci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `GSCI_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `GSCI_ASSERT_NEXT(a_m_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result data changed while stalled")
    `GSCI_ASSERT_NEXT(a_eval_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser[0], !s_tready, "input taken straight after an evaluate beat")
    `GSCI_ASSERT_NEXT(a_load_free, aclk, aresetn, s_tvalid && s_tready && !s_tuser[0], s_tready, "load beat blocked the input")
    `GSCI_ASSERT(a_out_from_busy, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result appeared without an evaluation in progress")

endmodule

bind gradient_stop_color_interpolator_core gsci_checker u_gsci_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb.sv]
module tb;

    // Run-time guard: far above the slowest legal run.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 750;
    localparam int TAIL_CYCLES  = 64;

    // Reference behaviour of the stop table. It keeps its own copy of the
    // offsets, colours, stop count and last offset, and queues the colour that
    // each evaluate beat must return.
    class colour_stop_board;
        logic [15:0] offs [gsci_pkg::MAX_STOPS];
        logic [31:0] cols [gsci_pkg::MAX_STOPS];
        int unsigned count;
        logic [15:0] last_off;
        logic [31:0] expected_colours [$];
        int errors;
        int accepted;
        int loads;
        int dropped;
        int clamped;
        int evals;
        int blended;
        int checked;

        function new();
            count    = 0;
            last_off = '0;
            errors   = 0;
            accepted = 0;
            loads    = 0;
            dropped  = 0;
            clamped  = 0;
            evals    = 0;
            blended  = 0;
            checked  = 0;
        endfunction

        function int waiting();
            return expected_colours.size();
        endfunction

        // Weighted average of two channels, rounded to nearest with ties upward.
        function logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [16:0] t,
                                   logic [16:0] d);
            logic [31:0] acc;
            acc = 32'(a) * 32'(d - t) + 32'(b) * 32'(t) + 32'(d >> 1);
            acc = acc / 32'(d);
            return (acc > 32'd255) ? 8'hFF : acc[7:0];
        endfunction

        function logic [31:0] colour_at(logic [15:0] pos);
            int unsigned k;
            logic [16:0] p;
            logic [16:0] q;
            logic [16:0] d;
            logic [16:0] t;
            logic [31:0] res;
            if (count == 0)
                return 32'h0;
            if (count == 1 || pos <= offs[0])
                return cols[0];
            if (pos >= offs[count-1])
                return cols[count-1];
            k = 1;
            while (k < count - 1 && offs[k] < pos)
                k++;
            p = {1'b0, offs[k-1]};
            q = {1'b0, offs[k]};
            d = q - p;
            t = {1'b0, pos} - p;
            if (d == 0)
                return cols[k];
            blended++;
            res = '0;
            for (int c = 0; c < gsci_pkg::LANES; c++)
                res[c*8 +: 8] = blend(cols[k-1][c*8 +: 8], cols[k][c*8 +: 8], t, d);
            return res;
        endfunction

        // Called for every accepted input beat.
        function void note_beat(logic fn, logic first, logic [15:0] off,
                                logic [31:0] col, logic [15:0] pos);
            logic [15:0] o;
            accepted++;
            if (fn == gsci_pkg::FUNC_LOAD) begin
                if (first) begin
                    count    = 0;
                    last_off = '0;
                end
                if (count >= gsci_pkg::MAX_STOPS) begin
                    dropped++;
                    return;
                end
                o = off;
                if (o < last_off)
                    o = last_off;
                if (o > gsci_pkg::ONE_Q15) begin
                    o = gsci_pkg::ONE_Q15;
                    clamped++;
                end
                offs[count] = o;
                cols[count] = col;
                count++;
                last_off = o;
                loads++;
            end else begin
                expected_colours.push_back(colour_at(pos));
                evals++;
            end
        endfunction

        // Called for every accepted result beat.
        function void check_colour(logic [31:0] got);
            logic [31:0] want;
            string lane_name [4];
            lane_name = '{"red", "green", "blue", "alpha"};
            if (expected_colours.size() == 0) begin
                $display("%0t: unexpected result beat %h with nothing outstanding",
                         $time, got);
                errors++;
                return;
            end
            want = expected_colours.pop_front();
            checked++;
            for (int c = 0; c < gsci_pkg::LANES; c++) begin
                if (got[c*8 +: 8] !== want[c*8 +: 8]) begin
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                             lane_name[c], want[c*8 +: 8], got[c*8 +: 8]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    colour_stop_board board = new();

    // When set, neither side inserts idle cycles, so beats go back to back.
    bit burst       = 1'b0;
    int stall_left  = 0;
    int cycle_count = 0;

    always #10 aclk = ~aclk;

    gradient_stop_color_interpolator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result monitor: every accepted result beat is checked, and the receiver
    // then draws how long it will hold tready low before taking the next one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_colour(m_tdata);
            stall_left = burst ? 0 : $urandom_range(0, 11);
        end
    end

    // Receiver: tready changes only on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Drives one input beat after a random gap and waits until it is taken.
    // Inputs change on the falling edge only; tvalid gets one update per edge.
    task automatic send_beat(logic fn, logic first, logic [15:0] off,
                             logic [31:0] col, logic [15:0] pos);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, col, off};
        s_tuser  <= {first, fn};
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_beat(fn, first, off, col, pos);
    endtask

    // The position field rides along on load beats but must be ignored.
    task automatic send_load(logic first, logic [15:0] off, logic [31:0] col);
        send_beat(gsci_pkg::FUNC_LOAD, first, off, col, 16'($urandom));
    endtask

    // Likewise the stop fields on evaluate beats.
    task automatic send_eval(logic [15:0] pos);
        send_beat(gsci_pkg::FUNC_EVAL, 1'($urandom), 16'($urandom), $urandom, pos);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge aclk);
    endtask

    // A gradient definition: mostly rising offsets with random colours, now and
    // then a wild offset (beyond 1.0 or below the previous one) or a repeated
    // offset. Some runs are long enough to overfill the table, and a few
    // append to the current table instead of restarting it.
    task automatic send_ramp();
        int n;
        int pick;
        int unsigned cur;
        logic [15:0] off;
        logic restart;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 19) : $urandom_range(1, 6);
        cur = $urandom_range(0, 8192);
        restart = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                off = 16'($urandom);
            end else if (pick == 1) begin
                off = (cur > 65535) ? 16'hFFFF : 16'(cur);
            end else begin
                cur = cur + $urandom_range(0, 65536 / (n + 1));
                off = (cur > 65535) ? 16'hFFFF : 16'(cur);
            end
            send_load(restart && i == 0, off, $urandom);
        end
    endtask

    // A handful of look-ups: mostly inside 0..1.0, some right on a stored
    // offset or one either side of it, and some anywhere in 16 bits.
    task automatic send_probes();
        int m;
        int sel;
        logic [15:0] pos;
        m = $urandom_range(1, 8);
        repeat (m) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                pos = 16'($urandom);
            else if (sel < 3 && board.count > 0)
                pos = board.offs[$urandom_range(0, board.count - 1)]
                      + 16'($urandom_range(0, 2)) - 16'd1;
            else
                pos = 16'($urandom_range(0, 32768));
            send_eval(pos);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. An empty table gives transparent black.
        send_eval(16'h0000);
        send_eval(16'hFFFF);
        // A single stop, whose offset lies beyond 1.0 at first.
        send_load(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_load(1'b1, 16'h4000, 32'hFFFF_FFFF);
        send_eval(16'h0000);
        send_eval(16'hFFFF);
        // An offset below the previous one is raised to it, and one beyond
        // 1.0 is clamped.
        send_load(1'b0, 16'h0000, 32'h0000_0000);
        send_load(1'b0, 16'hFFFF, 32'h80FF_0001);
        send_eval(16'h4000);
        send_eval(16'h4001);
        send_eval(16'h6000);
        send_eval(16'h7FFF);
        send_eval(16'h8000);
        send_eval(16'hFFFF);
        // Full-range ramp from black to white: midpoint tie and near-ends.
        send_load(1'b1, 16'h0000, 32'h0000_0000);
        send_load(1'b0, 16'h8000, 32'hFFFF_FFFF);
        send_eval(16'h0001);
        send_eval(16'h4000);
        send_eval(16'h7FFF);
        // Two stops both at 1.0, the second raised from zero.
        send_load(1'b1, 16'h8000, 32'h1234_5678);
        send_load(1'b0, 16'h0000, 32'hA5C3_3C5A);
        send_eval(16'h7FFF);
        send_eval(16'h8000);

        // Let the pipeline empty completely before the random part.
        drain();

        while (board.accepted < RANDOM_BEATS) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) begin
                // A stray beat with every field random.
                send_beat(1'($urandom), 1'($urandom), 16'($urandom), $urandom,
                          16'($urandom));
            end else begin
                send_ramp();
                send_probes();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst = 1'b0;
        while (board.waiting() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d stop loads (%0d dropped on a full table, %0d clamped to 1.0)",
                 board.loads, board.dropped, board.clamped);
        $display("and %0d colour look-ups, %0d of them blended between stops, %0d checked.",
                 board.evals, board.blended, board.checked);
        if (board.errors == 0 && board.waiting() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
